### rtl/core/gbre_pkg.sv
package gbre_pkg;

   localparam logic [31:0] HDR_POSITION = 32'h3F3F04AC;
   localparam logic [31:0] HDR_VELOCITY = 32'h3F3F05AC;
   localparam logic [31:0] HDR_DOP      = 32'h3F3F0BAC;
   localparam logic [31:0] HDR_GEODETIC = 32'h3F3F0EAC;
   localparam logic [31:0] HDR_TIME     = 32'h3F3F0FAC;

   localparam logic [3:0] IDLE_POS  = 4'd15;
   localparam logic [3:0] IDLE_VEL  = 4'd15;
   localparam logic [2:0] IDLE_DOP  = 3'd7;
   localparam logic [4:0] IDLE_GEO  = 5'd31;
   localparam logic [2:0] IDLE_TIME = 3'd7;

   localparam logic [3:0] POS_SLOTS  = 4'd12;
   localparam logic [3:0] VEL_SLOTS  = 4'd12;
   localparam logic [2:0] DOP_SLOTS  = 3'd4;
   localparam logic [4:0] GEO_SLOTS  = 5'd16;
   localparam logic [2:0] TIME_SLOTS = 3'd7;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] speed_x;
      logic signed [31:0] speed_y;
      logic signed [31:0] speed_z;
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic signed [31:0] altitude;
      logic [15:0]        pdop_value;
      logic [55:0]        time_stamp;
   } record_type;

   function automatic logic [31:0] shift_in32(input logic [31:0] w, input logic [7:0] b);
      return {b, w[31:8]};
   endfunction

   function automatic logic [15:0] shift_in16(input logic [15:0] w, input logic [7:0] b);
      return {b, w[15:8]};
   endfunction

endpackage

### rtl/core/gbre_parser.sv
module gbre_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   output logic                   record_end,
   output gbre_pkg::record_type   record
);

   logic [31:0] window_ff, window_in;
   logic [31:0] pos_words_ff [3];
   logic [31:0] pos_words_in [3];
   logic [31:0] vel_words_ff [3];
   logic [31:0] vel_words_in [3];
   logic [31:0] geo_words_ff [3];
   logic [31:0] geo_words_in [3];
   logic [15:0] pdop_ff, pdop_in;
   logic [7:0]  clock_bytes_ff [5];
   logic [7:0]  clock_bytes_in [5];
   logic [15:0] year_ff, year_in;
   logic [3:0]  pos_idx_ff, pos_idx_in;
   logic [3:0]  vel_idx_ff, vel_idx_in;
   logic [2:0]  dop_idx_ff, dop_idx_in;
   logic [4:0]  geo_idx_ff, geo_idx_in;
   logic [2:0]  time_idx_ff, time_idx_in;
   logic [31:0] shifted;
   logic [1:0]  geo_k;
   logic        time_done;

   always_comb begin
      shifted        = {window_ff[23:0], rx_byte};
      pos_words_in   = pos_words_ff;
      vel_words_in   = vel_words_ff;
      geo_words_in   = geo_words_ff;
      pdop_in        = pdop_ff;
      clock_bytes_in = clock_bytes_ff;
      year_in        = year_ff;
      pos_idx_in     = pos_idx_ff;
      vel_idx_in     = vel_idx_ff;
      dop_idx_in     = dop_idx_ff;
      geo_idx_in     = geo_idx_ff;
      time_idx_in    = time_idx_ff;
      geo_k          = geo_idx_ff[3:2] - 2'd1;
      time_done      = 1'b0;

      // running counters take the byte before the header compare
      if (pos_idx_ff < gbre_pkg::POS_SLOTS) begin
         pos_words_in[pos_idx_ff[3:2]] =
            gbre_pkg::shift_in32(pos_words_ff[pos_idx_ff[3:2]], rx_byte);
         pos_idx_in = (pos_idx_ff == gbre_pkg::POS_SLOTS - 4'd1) ?
                      gbre_pkg::IDLE_POS : pos_idx_ff + 4'd1;
      end
      if (vel_idx_ff < gbre_pkg::VEL_SLOTS) begin
         vel_words_in[vel_idx_ff[3:2]] =
            gbre_pkg::shift_in32(vel_words_ff[vel_idx_ff[3:2]], rx_byte);
         vel_idx_in = (vel_idx_ff == gbre_pkg::VEL_SLOTS - 4'd1) ?
                      gbre_pkg::IDLE_VEL : vel_idx_ff + 4'd1;
      end
      if (dop_idx_ff < gbre_pkg::DOP_SLOTS) begin
         if (dop_idx_ff[1]) begin
            pdop_in = gbre_pkg::shift_in16(pdop_ff, rx_byte);
         end
         dop_idx_in = (dop_idx_ff == gbre_pkg::DOP_SLOTS - 3'd1) ?
                      gbre_pkg::IDLE_DOP : dop_idx_ff + 3'd1;
      end
      if (geo_idx_ff < gbre_pkg::GEO_SLOTS) begin
         // first four bytes skipped
         if (geo_idx_ff[3:2] != 2'd0) begin
            geo_words_in[geo_k] = gbre_pkg::shift_in32(geo_words_ff[geo_k], rx_byte);
         end
         geo_idx_in = (geo_idx_ff == gbre_pkg::GEO_SLOTS - 5'd1) ?
                      gbre_pkg::IDLE_GEO : geo_idx_ff + 5'd1;
      end
      if (time_idx_ff < gbre_pkg::TIME_SLOTS) begin
         if (time_idx_ff < 3'd5) begin
            clock_bytes_in[time_idx_ff] = rx_byte;
         end else begin
            year_in = gbre_pkg::shift_in16(year_ff, rx_byte);
         end
         if (time_idx_ff == gbre_pkg::TIME_SLOTS - 3'd1) begin
            time_idx_in = gbre_pkg::IDLE_TIME;
            time_done   = 1'b1;
         end else begin
            time_idx_in = time_idx_ff + 3'd1;
         end
      end

      // one header at most; position header cancels a record end
      if (shifted == gbre_pkg::HDR_POSITION) begin
         time_done  = 1'b0;
         pos_idx_in = 4'd0;
      end else if (shifted == gbre_pkg::HDR_VELOCITY) begin
         vel_idx_in = 4'd0;
      end else if (shifted == gbre_pkg::HDR_DOP) begin
         dop_idx_in = 3'd0;
      end else if (shifted == gbre_pkg::HDR_GEODETIC) begin
         geo_idx_in = 5'd0;
      end else if (shifted == gbre_pkg::HDR_TIME) begin
         time_idx_in = 3'd0;
      end

      window_in  = time_done ? 32'd0 : shifted;
      record_end = step & time_done;

      record.pos_x      = pos_words_in[0];
      record.pos_y      = pos_words_in[1];
      record.pos_z      = pos_words_in[2];
      record.speed_x    = vel_words_in[0];
      record.speed_y    = vel_words_in[1];
      record.speed_z    = vel_words_in[2];
      record.latitude   = geo_words_in[0];
      record.longitude  = geo_words_in[1];
      record.altitude   = geo_words_in[2];
      record.pdop_value = pdop_in;
      record.time_stamp = {clock_bytes_in[0], clock_bytes_in[1], clock_bytes_in[2],
                           clock_bytes_in[3], clock_bytes_in[4], year_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 32'd0;
         pdop_ff     <= 16'd1;
         year_ff     <= 16'd1;
         pos_idx_ff  <= gbre_pkg::IDLE_POS;
         vel_idx_ff  <= gbre_pkg::IDLE_VEL;
         dop_idx_ff  <= gbre_pkg::IDLE_DOP;
         geo_idx_ff  <= gbre_pkg::IDLE_GEO;
         time_idx_ff <= gbre_pkg::IDLE_TIME;
         for (int i = 0; i < 3; i++) begin
            pos_words_ff[i] <= 32'd1;
            vel_words_ff[i] <= 32'd1;
            geo_words_ff[i] <= 32'd1;
         end
         for (int i = 0; i < 5; i++) begin
            clock_bytes_ff[i] <= 8'd1;
         end
      end else if (step) begin
         window_ff      <= window_in;
         pdop_ff        <= pdop_in;
         year_ff        <= year_in;
         pos_idx_ff     <= pos_idx_in;
         vel_idx_ff     <= vel_idx_in;
         dop_idx_ff     <= dop_idx_in;
         geo_idx_ff     <= geo_idx_in;
         time_idx_ff    <= time_idx_in;
         pos_words_ff   <= pos_words_in;
         vel_words_ff   <= vel_words_in;
         geo_words_ff   <= geo_words_in;
         clock_bytes_ff <= clock_bytes_in;
      end
   end

   a_pos_idx_range: assert property (@(posedge clock) disable iff (reset)
      pos_idx_ff < gbre_pkg::POS_SLOTS || pos_idx_ff == gbre_pkg::IDLE_POS)
      else $error("position counter out of range");

   a_geo_idx_range: assert property (@(posedge clock) disable iff (reset)
      geo_idx_ff < gbre_pkg::GEO_SLOTS || geo_idx_ff == gbre_pkg::IDLE_GEO)
      else $error("geodetic counter out of range");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      record_end |=> window_ff == 32'd0)
      else $error("window not cleared after record");

   a_end_from_time: assert property (@(posedge clock) disable iff (reset)
      record_end |=> time_idx_ff == gbre_pkg::IDLE_TIME || time_idx_ff == 3'd0)
      else $error("record end without time counter finishing");

endmodule

### rtl/core/gps_binary_record_extractor.sv
// Takes one received GPS word per cycle and, when the seventh byte of a time
// block arrives, delivers the assembled record (position, velocity, geodetic
// words, PDOP and time) in the next cycle through an output register.
// A new byte is taken every cycle as long as the output register is empty or
// being drained in the same cycle; the input stalls on every cycle in which a
// record waits at the result port and rsp_ready is low.
module gps_binary_record_extractor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_speed_x,
   output logic signed [31:0] rsp_speed_y,
   output logic signed [31:0] rsp_speed_z,
   output logic signed [31:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic signed [31:0] rsp_altitude,
   output logic [15:0]        rsp_pdop_value,
   output logic [55:0]        rsp_time_stamp
);

   logic                 step;
   logic                 record_end;
   gbre_pkg::record_type record;
   gbre_pkg::record_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   gbre_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (req_rx_byte),
      .record_end (record_end),
      .record     (record)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (record_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (record_end) begin
         rsp_ff <= record;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = rsp_ff.pos_x;
   assign rsp_pos_y      = rsp_ff.pos_y;
   assign rsp_pos_z      = rsp_ff.pos_z;
   assign rsp_speed_x    = rsp_ff.speed_x;
   assign rsp_speed_y    = rsp_ff.speed_y;
   assign rsp_speed_z    = rsp_ff.speed_z;
   assign rsp_latitude   = rsp_ff.latitude;
   assign rsp_longitude  = rsp_ff.longitude;
   assign rsp_altitude   = rsp_ff.altitude;
   assign rsp_pdop_value = rsp_ff.pdop_value;
   assign rsp_time_stamp = rsp_ff.time_stamp;

   a_record_lands: assert property (@(posedge clock) disable iff (reset)
      record_end |=> rsp_valid_ff)
      else $error("record end did not load output register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      record_end |-> (!rsp_valid_ff || rsp_ready))
      else $error("record would overwrite pending result");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && !record_end) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

### tb/gbre_record_compare.sv
module gbre_record_compare (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_pos_x,
   input  logic signed [31:0] rsp_pos_y,
   input  logic signed [31:0] rsp_pos_z,
   input  logic signed [31:0] rsp_speed_x,
   input  logic signed [31:0] rsp_speed_y,
   input  logic signed [31:0] rsp_speed_z,
   input  logic signed [31:0] rsp_latitude,
   input  logic signed [31:0] rsp_longitude,
   input  logic signed [31:0] rsp_altitude,
   input  logic [15:0]        rsp_pdop_value,
   input  logic [55:0]        rsp_time_stamp,
   output int                 errors,
   output int                 pending,
   output int                 records
);

   gbre_pkg::record_type records_q[$];

   logic [31:0] window;
   logic [31:0] pos_w[3];
   logic [31:0] vel_w[3];
   logic [31:0] geo_w[3];
   logic [15:0] pdop;
   logic [7:0]  clk_b[5];
   logic [15:0] year;
   logic [3:0]  pos_idx;
   logic [3:0]  vel_idx;
   logic [2:0]  dop_idx;
   logic [4:0]  geo_idx;
   logic [2:0]  tim_idx;

   task automatic clear_state();
      window = '0;
      for (int i = 0; i < 3; i++) begin
         pos_w[i] = 32'd1;
         vel_w[i] = 32'd1;
         geo_w[i] = 32'd1;
      end
      for (int i = 0; i < 5; i++)
         clk_b[i] = 8'd1;
      pdop    = 16'd1;
      year    = 16'd1;
      pos_idx = gbre_pkg::IDLE_POS;
      vel_idx = gbre_pkg::IDLE_VEL;
      dop_idx = gbre_pkg::IDLE_DOP;
      geo_idx = gbre_pkg::IDLE_GEO;
      tim_idx = gbre_pkg::IDLE_TIME;
      records_q.delete();
   endtask

   // Advance the parser by one word; queue a record when a time block ends.
   task automatic absorb_byte(input logic [7:0] b);
      logic                 done;
      int                   k;
      gbre_pkg::record_type rec;
      done   = 1'b0;
      window = {window[23:0], b};

      if (pos_idx < gbre_pkg::POS_SLOTS) begin
         k = pos_idx[3:2];
         pos_w[k] = {b, pos_w[k][31:8]};
         pos_idx = (pos_idx == gbre_pkg::POS_SLOTS - 4'd1) ?
                   gbre_pkg::IDLE_POS : pos_idx + 4'd1;
      end
      if (vel_idx < gbre_pkg::VEL_SLOTS) begin
         k = vel_idx[3:2];
         vel_w[k] = {b, vel_w[k][31:8]};
         vel_idx = (vel_idx == gbre_pkg::VEL_SLOTS - 4'd1) ?
                   gbre_pkg::IDLE_VEL : vel_idx + 4'd1;
      end
      if (dop_idx < gbre_pkg::DOP_SLOTS) begin
         if (dop_idx >= 3'd2)
            pdop = {b, pdop[15:8]};
         dop_idx = (dop_idx == gbre_pkg::DOP_SLOTS - 3'd1) ?
                   gbre_pkg::IDLE_DOP : dop_idx + 3'd1;
      end
      if (geo_idx < gbre_pkg::GEO_SLOTS) begin
         // first four geodetic bytes are skipped
         if (geo_idx >= 5'd4) begin
            k = int'(geo_idx[3:2]) - 1;
            geo_w[k] = {b, geo_w[k][31:8]};
         end
         geo_idx = (geo_idx == gbre_pkg::GEO_SLOTS - 5'd1) ?
                   gbre_pkg::IDLE_GEO : geo_idx + 5'd1;
      end
      if (tim_idx < gbre_pkg::TIME_SLOTS) begin
         if (tim_idx < 3'd5)
            clk_b[tim_idx] = b;
         else
            year = {b, year[15:8]};
         if (tim_idx == gbre_pkg::TIME_SLOTS - 3'd1) begin
            tim_idx = gbre_pkg::IDLE_TIME;
            done = 1'b1;
         end else begin
            tim_idx = tim_idx + 3'd1;
         end
      end

      // a position header on the last time byte suppresses the record
      if (window == gbre_pkg::HDR_POSITION) begin
         done    = 1'b0;
         pos_idx = '0;
      end else if (window == gbre_pkg::HDR_VELOCITY) begin
         vel_idx = '0;
      end else if (window == gbre_pkg::HDR_DOP) begin
         dop_idx = '0;
      end else if (window == gbre_pkg::HDR_GEODETIC) begin
         geo_idx = '0;
      end else if (window == gbre_pkg::HDR_TIME) begin
         tim_idx = '0;
      end

      if (done) begin
         window         = '0;
         rec.pos_x      = pos_w[0];
         rec.pos_y      = pos_w[1];
         rec.pos_z      = pos_w[2];
         rec.speed_x    = vel_w[0];
         rec.speed_y    = vel_w[1];
         rec.speed_z    = vel_w[2];
         rec.latitude   = geo_w[0];
         rec.longitude  = geo_w[1];
         rec.altitude   = geo_w[2];
         rec.pdop_value = pdop;
         rec.time_stamp = {clk_b[0], clk_b[1], clk_b[2], clk_b[3], clk_b[4], year};
         records_q.push_back(rec);
         records++;
      end
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
   endtask

   task automatic compare_record();
      gbre_pkg::record_type rec;
      if (records_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: record word with none expected", $time);
      end else begin
         rec = records_q.pop_front();
         if (rsp_pos_x !== rec.pos_x)
            note_mismatch("pos_x", rec.pos_x, rsp_pos_x);
         if (rsp_pos_y !== rec.pos_y)
            note_mismatch("pos_y", rec.pos_y, rsp_pos_y);
         if (rsp_pos_z !== rec.pos_z)
            note_mismatch("pos_z", rec.pos_z, rsp_pos_z);
         if (rsp_speed_x !== rec.speed_x)
            note_mismatch("speed_x", rec.speed_x, rsp_speed_x);
         if (rsp_speed_y !== rec.speed_y)
            note_mismatch("speed_y", rec.speed_y, rsp_speed_y);
         if (rsp_speed_z !== rec.speed_z)
            note_mismatch("speed_z", rec.speed_z, rsp_speed_z);
         if (rsp_latitude !== rec.latitude)
            note_mismatch("latitude", rec.latitude, rsp_latitude);
         if (rsp_longitude !== rec.longitude)
            note_mismatch("longitude", rec.longitude, rsp_longitude);
         if (rsp_altitude !== rec.altitude)
            note_mismatch("altitude", rec.altitude, rsp_altitude);
         if (rsp_pdop_value !== rec.pdop_value)
            note_mismatch("pdop_value", rec.pdop_value, rsp_pdop_value);
         if (rsp_time_stamp !== rec.time_stamp)
            note_mismatch("time_stamp", rec.time_stamp, rsp_time_stamp);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         errors  = 0;
         records = 0;
      end else begin
         // predict first so a same-edge record would still find its entry
         if (req_valid && req_ready)
            absorb_byte(req_rx_byte);
         if (rsp_valid && rsp_ready)
            compare_record();
      end
      pending = records_q.size();
   end

endmodule

### tb/tb_gps_binary_record_extractor.sv
module tb_gps_binary_record_extractor;

   typedef enum int {
      FR_POSITION,
      FR_VELOCITY,
      FR_DOP,
      FR_GEODETIC,
      FR_TIME,
      FR_NOISE,
      FR_CUT_HEADER
   } frame_kind_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [31:0] rsp_pos_z;
   logic signed [31:0] rsp_speed_x;
   logic signed [31:0] rsp_speed_y;
   logic signed [31:0] rsp_speed_z;
   logic signed [31:0] rsp_latitude;
   logic signed [31:0] rsp_longitude;
   logic signed [31:0] rsp_altitude;
   logic [15:0]        rsp_pdop_value;
   logic [55:0]        rsp_time_stamp;

   int fail_count;
   int pending;
   int records;
   int req_idle_pct;
   int rsp_idle_pct;
   int word_count;

   gps_binary_record_extractor uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_pos_z      (rsp_pos_z),
      .rsp_speed_x    (rsp_speed_x),
      .rsp_speed_y    (rsp_speed_y),
      .rsp_speed_z    (rsp_speed_z),
      .rsp_latitude   (rsp_latitude),
      .rsp_longitude  (rsp_longitude),
      .rsp_altitude   (rsp_altitude),
      .rsp_pdop_value (rsp_pdop_value),
      .rsp_time_stamp (rsp_time_stamp)
   );

   gbre_record_compare rec_cmp (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_pos_z      (rsp_pos_z),
      .rsp_speed_x    (rsp_speed_x),
      .rsp_speed_y    (rsp_speed_y),
      .rsp_speed_z    (rsp_speed_z),
      .rsp_latitude   (rsp_latitude),
      .rsp_longitude  (rsp_longitude),
      .rsp_altitude   (rsp_altitude),
      .rsp_pdop_value (rsp_pdop_value),
      .rsp_time_stamp (rsp_time_stamp),
      .errors         (fail_count),
      .pending        (pending),
      .records        (records)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic logic [31:0] header_of(input frame_kind_type k);
      case (k)
         FR_POSITION: return gbre_pkg::HDR_POSITION;
         FR_VELOCITY: return gbre_pkg::HDR_VELOCITY;
         FR_DOP:      return gbre_pkg::HDR_DOP;
         FR_GEODETIC: return gbre_pkg::HDR_GEODETIC;
         default:     return gbre_pkg::HDR_TIME;
      endcase
   endfunction

   // Holds the word until accepted; called and returns at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      word_count++;
      @(negedge clock);
   endtask

   // header goes out oldest byte first, so it lands in the window as written
   task automatic send_header(input logic [31:0] hdr);
      for (int i = 3; i >= 0; i--)
         send_byte(hdr[i*8 +: 8]);
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [31:0] hdr;
      int          len;
      int          cut;
      int          n;
      hdr = header_of(kind);
      case (kind)
         FR_POSITION: len = gbre_pkg::POS_SLOTS;
         FR_VELOCITY: len = gbre_pkg::VEL_SLOTS;
         FR_DOP:      len = gbre_pkg::DOP_SLOTS;
         FR_GEODETIC: len = gbre_pkg::GEO_SLOTS;
         default:     len = gbre_pkg::TIME_SLOTS;
      endcase
      if (kind == FR_NOISE) begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte($urandom_range(255));
      end else if (kind == FR_CUT_HEADER) begin
         hdr = header_of(frame_kind_type'($urandom_range(4)));
         n = $urandom_range(1, 3);
         for (int i = 3; i > 3 - n; i--)
            send_byte(hdr[i*8 +: 8]);
      end else begin
         // a short payload leaves the counter running into the next header
         cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : len;
         send_header(hdr);
         repeat (cut) send_byte($urandom_range(255));
      end
   endtask

   initial begin
      logic [7:0]     tail [7];
      frame_kind_type kind;
      int             r;
      int             frames;
      int             spin;

      tail         = '{8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'hFF};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'h00;
      req_idle_pct = 7;
      rsp_idle_pct = 64;
      word_count   = 0;
      frames       = 0;
      spin         = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // time block whose last four bytes form the position header: no record
      send_header(gbre_pkg::HDR_TIME);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_header(gbre_pkg::HDR_POSITION);
      repeat (4) send_byte(8'hFF);
      repeat (4) send_byte(8'h00);
      // time header lands inside the running position payload
      send_header(gbre_pkg::HDR_TIME);
      foreach (tail[i]) send_byte(tail[i]);

      while ((word_count < 1750 || records < 40) && frames < 4000) begin
         if (word_count < 583) begin
            req_idle_pct = 7;
            rsp_idle_pct = 64;
         end else if (word_count < 1166) begin
            req_idle_pct = 64;
            rsp_idle_pct = 7;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         r = $urandom_range(99);
         if (r < 30)
            kind = FR_TIME;
         else if (r < 45)
            kind = FR_POSITION;
         else if (r < 60)
            kind = FR_VELOCITY;
         else if (r < 70)
            kind = FR_DOP;
         else if (r < 85)
            kind = FR_GEODETIC;
         else if (r < 95)
            kind = FR_NOISE;
         else
            kind = FR_CUT_HEADER;
         send_frame(kind);
         frames++;
      end
      req_valid <= 1'b0;

      while (pending != 0 && spin < 20000) begin
         @(negedge clock);
         spin++;
      end
      repeat (10) @(negedge clock);

      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
